FILE: hw/rtl/kthrq_pkg.sv
`default_nettype none

package kthrq_pkg;

  typedef enum logic [1:0] {
    OP_REMOVE = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_REMOVED  = 3'd0,
    ST_NONE     = 3'd1,
    ST_APPENDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_CLEARED  = 3'd4
  } status_t;

  localparam int unsigned RANK_W  = 11;
  localparam int unsigned VALUE_W = 31;

  typedef struct packed {
    logic [1:0]         operation;
    logic [RANK_W-1:0]  rank;
    logic [VALUE_W-1:0] item_value;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [VALUE_W-1:0] removed_value;
  } out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/kthrq_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module kthrq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/kthrq_ctrl.sv
`default_nettype none

// Sequencer: count-tree descent, then read-modify-write back up the path.
module kthrq_ctrl #(
  parameter int unsigned CAPACITY = 1024,
  localparam int unsigned LVLS = $clog2(CAPACITY),
  localparam int unsigned TAW  = LVLS + 1,
  localparam int unsigned SW   = LVLS,
  localparam int unsigned CW   = $clog2(CAPACITY + 1),
  localparam int unsigned TW   = $clog2(CAPACITY + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire kthrq_pkg::in_t      item,
  output logic                     busy,
  output logic                     out_strobe,
  output kthrq_pkg::out_t          out_result,
  // count tree port
  output logic                     t_we,
  output logic [TAW-1:0]           t_waddr,
  output logic [CW-1:0]            t_wdata,
  output logic                     t_re,
  output logic [TAW-1:0]           t_raddr,
  input  wire logic [CW-1:0]       t_rdata,
  // value store port
  output logic                     v_we,
  output logic [SW-1:0]            v_waddr,
  output logic [kthrq_pkg::VALUE_W-1:0] v_wdata,
  output logic                     v_re,
  output logic [SW-1:0]            v_raddr,
  input  wire logic [kthrq_pkg::VALUE_W-1:0] v_rdata
);

  localparam int unsigned LW   = $clog2(LVLS + 1);
  localparam int unsigned CMPW = (CW > kthrq_pkg::RANK_W) ? CW : kthrq_pkg::RANK_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DESC,
    S_UP
  } state_t;

  state_t          state_r, state_nxt;
  logic            strobe_r, strobe_nxt;
  kthrq_pkg::out_t res_r, res_nxt;
  logic [TW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   present_r, present_nxt;
  logic [TAW-1:0]  node_r, node_nxt;
  logic [CW-1:0]   k_r, k_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  logic [SW-1:0]   mask_r, mask_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic            app_r, app_nxt;

  logic [TAW-1:0]  leaf_addr;
  logic [TAW-1:0]  child;
  logic            go_left;
  logic            stale;

  // leaf of the next free slot
  assign leaf_addr = {1'b1, tail_r[SW-1:0]};
  assign go_left   = (t_rdata >= k_r);
  assign child     = {node_r[TAW-2:0], ~go_left};
  // node not touched since the last clear: its first slot is the one being appended
  assign stale     = ((slot_r & mask_r) == '0);

  always_comb begin
    state_nxt   = state_r;
    strobe_nxt  = 1'b0;
    res_nxt     = res_r;
    tail_nxt    = tail_r;
    present_nxt = present_r;
    node_nxt    = node_r;
    k_nxt       = k_r;
    lvl_nxt     = lvl_r;
    mask_nxt    = mask_r;
    slot_nxt    = slot_r;
    app_nxt     = app_r;
    t_we        = 1'b0;
    t_waddr     = node_r;
    t_wdata     = '0;
    t_re        = 1'b0;
    t_raddr     = node_r;
    v_we        = 1'b0;
    v_waddr     = tail_r[SW-1:0];
    v_wdata     = item.item_value;
    v_re        = 1'b0;
    v_raddr     = child[SW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          res_nxt.removed_value = '0;
          unique case (item.operation)
            kthrq_pkg::OP_REMOVE: begin
              if ((item.rank == '0) || (CMPW'(item.rank) > CMPW'(present_r))) begin
                strobe_nxt     = 1'b1;
                res_nxt.status = kthrq_pkg::ST_NONE;
              end else begin
                k_nxt     = CW'(item.rank);
                node_nxt  = TAW'(1);
                lvl_nxt   = LW'(LVLS);
                app_nxt   = 1'b0;
                t_re      = 1'b1;
                t_raddr   = TAW'(2);
                state_nxt = S_DESC;
              end
            end
            kthrq_pkg::OP_APPEND: begin
              if (tail_r == TW'(CAPACITY)) begin
                strobe_nxt     = 1'b1;
                res_nxt.status = kthrq_pkg::ST_FULL;
              end else begin
                v_we        = 1'b1;
                t_we        = 1'b1;
                t_waddr     = leaf_addr;
                t_wdata     = CW'(1);
                t_re        = 1'b1;
                t_raddr     = leaf_addr >> 1;
                node_nxt    = leaf_addr >> 1;
                slot_nxt    = tail_r[SW-1:0];
                mask_nxt    = SW'(1);
                app_nxt     = 1'b1;
                tail_nxt    = tail_r + TW'(1);
                present_nxt = present_r + CW'(1);
                state_nxt   = S_UP;
              end
            end
            kthrq_pkg::OP_CLEAR: begin
              tail_nxt       = '0;
              present_nxt    = '0;
              strobe_nxt     = 1'b1;
              res_nxt.status = kthrq_pkg::ST_CLEARED;
            end
            default: begin
              strobe_nxt     = 1'b1;
              res_nxt.status = kthrq_pkg::ST_NONE;
            end
          endcase
        end
      end

      S_DESC: begin
        if (!go_left) begin
          k_nxt = k_r - t_rdata;
        end
        t_re = 1'b1;
        if (lvl_r == LW'(1)) begin
          // reached the leaf: fetch value, clear leaf, start the walk up
          v_re        = 1'b1;
          t_we        = 1'b1;
          t_waddr     = child;
          t_wdata     = '0;
          t_raddr     = node_r;
          slot_nxt    = child[SW-1:0];
          mask_nxt    = SW'(1);
          present_nxt = present_r - CW'(1);
          state_nxt   = S_UP;
        end else begin
          t_raddr  = {child[TAW-2:0], 1'b0};
          node_nxt = child;
          lvl_nxt  = lvl_r - LW'(1);
        end
      end

      S_UP: begin
        t_we = 1'b1;
        if (app_r) begin
          t_wdata = stale ? CW'(1) : (t_rdata + CW'(1));
        end else begin
          t_wdata = t_rdata - CW'(1);
        end
        if (node_r == TAW'(1)) begin
          strobe_nxt = 1'b1;
          if (app_r) begin
            res_nxt.status        = kthrq_pkg::ST_APPENDED;
            res_nxt.removed_value = '0;
          end else begin
            res_nxt.status        = kthrq_pkg::ST_REMOVED;
            res_nxt.removed_value = v_rdata;
          end
          state_nxt = S_IDLE;
        end else begin
          t_re     = 1'b1;
          t_raddr  = node_r >> 1;
          node_nxt = node_r >> 1;
          mask_nxt = (mask_r << 1) | SW'(1);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r  <= res_nxt;
    node_r <= node_nxt;
    k_r    <= k_nxt;
    lvl_r  <= lvl_nxt;
    mask_r <= mask_nxt;
    slot_r <= slot_nxt;
    app_r  <= app_nxt;
    if (!rst_n) begin
      state_r   <= S_IDLE;
      strobe_r  <= 1'b0;
      tail_r    <= '0;
      present_r <= '0;
    end else begin
      state_r   <= state_nxt;
      strobe_r  <= strobe_nxt;
      tail_r    <= tail_nxt;
      present_r <= present_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;
  assign out_result = res_r;

endmodule

`default_nettype wire

FILE: hw/rtl/kth_removal_queue_top.sv
`default_nettype none

// Ordered queue with removal by rank, held as an order-statistic count tree.
//
// Input channel: drive in_item with start high; the transaction is taken at
// the clock edge where start is high and busy is low. Operations: remove the
// k-th present entry (rank is one-based), append a value, clear the queue.
// Result channel: out_strobe is high for exactly one cycle with out_result;
// the receiver cannot stall, every result must be taken when shown.
//
// Operation sequences, L = clog2(CAPACITY) tree levels (10 at the default):
//   remove (valid rank): L levels descend the count tree in RAM, one level
//     per cycle, then the path back to the root is decremented, one
//     read-modify-write per cycle.
//   append: leaf write, then L increments up the path.
//   clear, full, invalid rank, unused code: result in the cycle after accept.
// busy drops in the strobe cycle, so the next transaction can be taken then.
//
// Reset (synchronous, rst_n low) empties the queue at once: a tree node is
// treated as zero until a slot it covers is appended, tracked by the tail
// pointer, so neither reset nor clear sweeps the RAMs.
module kth_removal_queue_top #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire kthrq_pkg::in_t  in_item,
  output logic                 out_strobe,
  output kthrq_pkg::out_t      out_result
);

  localparam int unsigned LVLS = $clog2(CAPACITY);
  localparam int unsigned TAW  = LVLS + 1;
  localparam int unsigned SW   = LVLS;
  localparam int unsigned CW   = $clog2(CAPACITY + 1);

  logic                          t_we, t_re;
  logic [TAW-1:0]                t_waddr, t_raddr;
  logic [CW-1:0]                 t_wdata, t_rdata;
  logic                          v_we, v_re;
  logic [SW-1:0]                 v_waddr, v_raddr;
  logic [kthrq_pkg::VALUE_W-1:0] v_wdata, v_rdata;

  kthrq_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .item       (in_item),
    .busy       (busy),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .t_we       (t_we),
    .t_waddr    (t_waddr),
    .t_wdata    (t_wdata),
    .t_re       (t_re),
    .t_raddr    (t_raddr),
    .t_rdata    (t_rdata),
    .v_we       (v_we),
    .v_waddr    (v_waddr),
    .v_wdata    (v_wdata),
    .v_re       (v_re),
    .v_raddr    (v_raddr),
    .v_rdata    (v_rdata)
  );

  // count tree: node 1 is the root, leaves at 2**L + slot
  kthrq_ram #(
    .WIDTH (CW),
    .DEPTH (2 ** TAW)
  ) u_tree_ram (
    .clk     (clk),
    .wr_en   (t_we),
    .wr_addr (t_waddr),
    .wr_data (t_wdata),
    .rd_en   (t_re),
    .rd_addr (t_raddr),
    .rd_data (t_rdata)
  );

  // appended values, one per slot
  kthrq_ram #(
    .WIDTH (kthrq_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_value_ram (
    .clk     (clk),
    .wr_en   (v_we),
    .wr_addr (v_waddr),
    .wr_data (v_wdata),
    .rd_en   (v_re),
    .rd_addr (v_raddr),
    .rd_data (v_rdata)
  );

  // A result never shows while a transaction is still in the tree walk.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // Clear answers in the next cycle.
  a_clear_resp: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_item.operation == kthrq_pkg::OP_CLEAR)) |=>
      (out_strobe && (out_result.status == kthrq_pkg::ST_CLEARED)))
    else $error("clear not answered");

  // Only a removal carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_result.status != kthrq_pkg::ST_REMOVED)) |->
      (out_result.removed_value == '0))
    else $error("value on non-removal result");

endmodule

`default_nettype wire
